### rtl/dnsqm_pkg.sv
// Shared types, constants and helper functions for the DNS query name matcher.
`timescale 1ns / 1ps

package dnsqm_pkg;

    // Longest prefix that is compared; longer configured lengths saturate here.
    localparam int MAX_PREFIX_CHARS  = 32;
    // Longest message that can still report a match.
    localparam int MAX_MESSAGE_BYTES = 1600;

    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int PREFIX_LEN_W = 6;
    localparam int PREFIX_REGS  = 4;
    localparam int PREFIX_BITS  = PREFIX_REGS * CFG_DATA_W;
    localparam int COUNT_W      = 11;

    localparam logic [PREFIX_LEN_W:0] PREFIX_CAP     = (PREFIX_LEN_W + 1)'(MAX_PREFIX_CHARS);
    localparam logic [COUNT_W-1:0]    COUNT_MAX      = '1;
    localparam logic [COUNT_W-1:0]    LAST_MSG_INDEX = COUNT_W'(MAX_MESSAGE_BYTES - 1);
    localparam logic [COUNT_W-1:0]    QDCOUNT_HI_IDX = COUNT_W'(4);
    localparam logic [COUNT_W-1:0]    QDCOUNT_LO_IDX = COUNT_W'(5);
    localparam logic [COUNT_W-1:0]    HEADER_END_IDX = COUNT_W'(11);
    localparam logic [7:0]            POINTER_MARK   = 8'd192;
    localparam logic [7:0]            DOT_CHAR       = 8'h2E;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PREFIX_LENGTH  = 3'd0,
        CFG_PREFIX_CHARS_0 = 3'd1,
        CFG_PREFIX_CHARS_1 = 3'd2,
        CFG_PREFIX_CHARS_2 = 3'd3,
        CFG_PREFIX_CHARS_3 = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        STAGE_HEADER,
        STAGE_LENGTH,
        STAGE_LABEL,
        STAGE_DONE
    } parse_stage_t;

    typedef struct packed {
        logic [PREFIX_LEN_W-1:0] prefix_length;
        logic [PREFIX_BITS-1:0]  prefix_chars;
    } dnsqm_cfg_t;

    typedef struct packed {
        logic valid;
        logic matched;
    } dnsqm_result_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] folded;
        folded = (c inside {[8'd65:8'd90]}) ? c + 8'd32 : c;
        return folded;
    endfunction

endpackage

### rtl/dnsqm_stream_if.sv
// Valid/ready channel interfaces for message bytes in and match results out.
`timescale 1ns / 1ps

interface dnsqm_query_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dnsqm_result_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

### rtl/dnsqm_cfg_regs.sv
// Configuration register file holding the prefix length and prefix characters.
`timescale 1ns / 1ps

module dnsqm_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dnsqm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dnsqm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output dnsqm_pkg::dnsqm_cfg_t             cfg
);
    import dnsqm_pkg::*;

    logic [PREFIX_LEN_W-1:0] prefix_length_reg;
    logic [CFG_DATA_W-1:0]   chars_reg [PREFIX_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_length_reg <= '0;
            for (int i = 0; i < PREFIX_REGS; i++)
            begin
                chars_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PREFIX_LENGTH:  prefix_length_reg <= cfg_wdata[PREFIX_LEN_W-1:0];
                CFG_PREFIX_CHARS_0: chars_reg[0] <= cfg_wdata;
                CFG_PREFIX_CHARS_1: chars_reg[1] <= cfg_wdata;
                CFG_PREFIX_CHARS_2: chars_reg[2] <= cfg_wdata;
                CFG_PREFIX_CHARS_3: chars_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.prefix_length = prefix_length_reg;
    assign cfg.prefix_chars  = {chars_reg[3], chars_reg[2], chars_reg[1], chars_reg[0]};

endmodule

### rtl/dnsqm_parser.sv
// Header and question name parser with case-insensitive prefix comparison.
`timescale 1ns / 1ps

module dnsqm_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    input  dnsqm_pkg::dnsqm_cfg_t    cfg,
    output dnsqm_pkg::dnsqm_result_t res
);
    import dnsqm_pkg::*;

    parse_stage_t            stage_reg,      stage_next;
    logic [COUNT_W-1:0]      count_reg,      count_next;
    logic [7:0]              qd_high_reg,    qd_high_next;
    logic                    single_reg,     single_next;
    logic [7:0]              left_reg,       left_next;
    logic [PREFIX_LEN_W-1:0] pos_reg,        pos_next;
    logic                    first_reg,      first_next;
    logic                    mismatch_reg,   mismatch_next;

    logic [PREFIX_LEN_W-1:0] eff_len;
    logic [7:0]              prefix_char;
    logic                    take_en;
    logic [7:0]              take_char;
    logic [7:0]              left_dec;

    always_comb
    begin
        eff_len = ({1'b0, cfg.prefix_length} > PREFIX_CAP) ? PREFIX_CAP[PREFIX_LEN_W-1:0]
                                                          : cfg.prefix_length;
        // Only the first 32 prefix characters are stored; the rest read as zero.
        prefix_char = pos_reg[PREFIX_LEN_W-1] ? 8'h00
                    : cfg.prefix_chars[{pos_reg[PREFIX_LEN_W-2:0], 3'b000} +: 8];
    end

    always_comb
    begin
        stage_next    = stage_reg;
        qd_high_next  = qd_high_reg;
        single_next   = single_reg;
        left_next     = left_reg;
        pos_next      = pos_reg;
        first_next    = first_reg;
        mismatch_next = mismatch_reg;
        count_next    = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        take_en       = 1'b0;
        take_char     = data_byte;
        left_dec      = left_reg - 8'd1;
        res           = '0;

        case (stage_reg)
            STAGE_HEADER:
            begin
                if (count_reg == QDCOUNT_HI_IDX)
                begin
                    qd_high_next = data_byte;
                end
                else if (count_reg == QDCOUNT_LO_IDX)
                begin
                    single_next = (qd_high_reg == 8'd0) && (data_byte == 8'd1);
                end
                if (count_reg == HEADER_END_IDX)
                begin
                    stage_next = STAGE_LENGTH;
                end
            end
            STAGE_LENGTH:
            begin
                if (data_byte >= POINTER_MARK)
                begin
                    mismatch_next = 1'b1;
                    stage_next    = STAGE_DONE;
                end
                else if (data_byte == 8'd0)
                begin
                    stage_next = STAGE_DONE;
                end
                else
                begin
                    // Every label after the first is preceded by a dot in the name.
                    take_en    = !first_reg;
                    take_char  = DOT_CHAR;
                    first_next = 1'b0;
                    left_next  = data_byte;
                    stage_next = STAGE_LABEL;
                end
            end
            STAGE_LABEL:
            begin
                take_en   = 1'b1;
                left_next = left_dec;
                if (left_dec == 8'd0)
                begin
                    stage_next = STAGE_LENGTH;
                end
            end
            default: ;
        endcase

        if (take_en && (pos_reg < eff_len))
        begin
            if (fold_case(take_char) != fold_case(prefix_char))
            begin
                mismatch_next = 1'b1;
            end
            pos_next = pos_reg + 1'b1;
        end

        if (last_byte)
        begin
            res.valid   = accept;
            res.matched = single_next && (count_reg <= LAST_MSG_INDEX) && (eff_len != '0)
                          && (pos_next >= eff_len) && !mismatch_next;
            stage_next    = STAGE_HEADER;
            count_next    = '0;
            qd_high_next  = '0;
            single_next   = 1'b0;
            left_next     = '0;
            pos_next      = '0;
            first_next    = 1'b1;
            mismatch_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg    <= STAGE_HEADER;
            count_reg    <= '0;
            qd_high_reg  <= '0;
            single_reg   <= 1'b0;
            left_reg     <= '0;
            pos_reg      <= '0;
            first_reg    <= 1'b1;
            mismatch_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_reg    <= stage_next;
            count_reg    <= count_next;
            qd_high_reg  <= qd_high_next;
            single_reg   <= single_next;
            left_reg     <= left_next;
            pos_reg      <= pos_next;
            first_reg    <= first_next;
            mismatch_reg <= mismatch_next;
        end
    end

endmodule

### rtl/dnsqm_out_buf.sv
// Two-entry result buffer: output register plus a skid entry.
`timescale 1ns / 1ps

module dnsqm_out_buf (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dnsqm_pkg::dnsqm_result_t push,
    output logic                     push_ready,
    output logic                     out_valid,
    output logic                     out_matched,
    input  logic                     out_ready
);
    import dnsqm_pkg::*;

    logic out_valid_reg,  out_valid_next;
    logic out_match_reg,  out_match_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_match_reg, skid_match_next;
    logic pop;

    always_comb
    begin
        pop             = out_valid_reg && out_ready;
        out_valid_next  = out_valid_reg;
        out_match_next  = out_match_reg;
        skid_valid_next = skid_valid_reg;
        skid_match_next = skid_match_reg;

        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_match_next  = skid_match_reg;
                skid_valid_next = push.valid;
                skid_match_next = push.matched;
            end
            else
            begin
                out_valid_next = push.valid;
                out_match_next = push.matched;
            end
        end
        else if (push.valid)
        begin
            // Output is held by the consumer; park the new result.
            skid_valid_next = 1'b1;
            skid_match_next = push.matched;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_match_reg  <= out_match_next;
        skid_match_reg <= skid_match_next;
    end

    assign push_ready  = !skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign out_matched = out_match_reg;

endmodule

### rtl/dns_query_name_matcher.sv
// Top level of the DNS query name prefix matcher.
//
//   Channel  Direction  Payload                Handshake
//   query    in         data_byte, last_byte   valid/ready
//   result   out        matched                valid/ready
//   cfg      in         cfg_index, cfg_wdata   cfg_we, no back-pressure
//
// One message byte is taken per cycle while query.ready is high; the parse registers
// update on the accepting edge. The result of a message is registered at the edge that
// accepts its last byte and is offered from the next cycle on if no earlier result waits.
// A two-entry result buffer lets bytes keep flowing while one result waits to be taken;
// query.ready drops only when both entries hold results.
// Reset returns the parser to the header stage and clears the configuration; no clearing
// pass is needed.
`timescale 1ns / 1ps

module dns_query_name_matcher (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dnsqm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dnsqm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    dnsqm_query_if.sink                       query,
    dnsqm_result_if.source                    result
);
    import dnsqm_pkg::*;

    dnsqm_cfg_t    cfg;
    dnsqm_result_t parse_res;
    logic          accept;
    logic          buf_ready;

    assign query.ready = buf_ready;
    assign accept      = query.valid && buf_ready;

    dnsqm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dnsqm_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (query.data_byte),
        .last_byte (query.last_byte),
        .cfg       (cfg),
        .res       (parse_res)
    );

    dnsqm_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (parse_res),
        .push_ready  (buf_ready),
        .out_valid   (result.valid),
        .out_matched (result.matched),
        .out_ready   (result.ready)
    );

endmodule

### rtl/dnsqm_checker.sv
// Port-level checker for the DNS query name matcher and its bind statement.
`timescale 1ns / 1ps

module dnsqm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready,
    input logic out_matched
);

    // A held result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // A held result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_matched))
        else $error("result changed while stalled");

    // With nothing pending, a byte that does not end a message yields no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_last && !out_valid |=> !out_valid)
        else $error("result appeared without a last byte");

    // With nothing pending, the last byte of a message yields a result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last && !out_valid |=> out_valid)
        else $error("missing result after last byte");

endmodule

bind dns_query_name_matcher dnsqm_checker u_dnsqm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (query.valid),
    .in_ready    (query.ready),
    .in_last     (query.last_byte),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_matched (result.matched)
);
